// ===== hdl/dfga_pkg.sv =====
//------------------------------------------------------------------------------
// dfga_pkg
// Shared constants and register indices for the dipole field
// gradient accumulator.
//------------------------------------------------------------------------------
package dfga_pkg;

  localparam int DataWidthDef = 32;
  localparam int FracBitsDef  = 16;
  localparam int AccWidthDef  = 48;
  localparam int CfgWidth     = 32;
  localparam logic [31:0] FieldCoefReset = 32'h0001_0000;

  // Register index of the field coefficient.
  localparam logic [1:0] RegFieldCoef = 2'd0;

endpackage

// ===== hdl/dfga_mul.sv =====
//------------------------------------------------------------------------------
// dfga_mul
// Registered signed fixed-point multiply with round half away from zero and
// saturation to a chosen output width.
//------------------------------------------------------------------------------
module dfga_mul import dfga_pkg::*; #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int OW = 32,
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] y
);

  localparam int PW = AW + BW;

  logic signed [PW-1:0] prod;
  logic        [PW-1:0] pmag;
  logic        [PW-1:0] rmag;
  logic                 neg;
  logic        [PW-1:0] lim;
  logic signed [OW-1:0] res;

  always_comb begin
    prod = PW'(a) * PW'(b);
    neg  = prod[PW-1];
    pmag = neg ? PW'(-prod) : PW'(prod);
    rmag = (pmag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim  = (PW'(1) << (OW - 1)) - PW'(neg ? 0 : 1);
    if (rmag > lim) begin
      rmag = lim;
    end
    res = neg ? OW'(-rmag) : OW'(rmag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y <= res;
    end
  end

endmodule

// ===== hdl/dfga_front.sv =====
//------------------------------------------------------------------------------
// dfga_front
// Input stage and two-entry queue. Items are taken here and the head item is
// held until the arithmetic engine has finished with it.
//------------------------------------------------------------------------------
module dfga_front import dfga_pkg::*; #(
  parameter int IW = 257
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [IW-1:0] in_data,
  output logic          q_valid,
  input  logic          q_take,
  output logic [IW-1:0] q_data
);

  logic [IW-1:0] slot [2];
  logic [1:0]    count;
  logic          rd_ptr;
  logic          wr_ptr;
  logic          push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
    if (rst) begin
      count  <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_take && q_valid);
    end
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) count == 2'd2 |-> !in_ready;
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

  property p_count_range;
    @(posedge clk) disable iff (rst) count != 2'd3;
  endproperty
  a_count_range: assert property (p_count_range) else $error("bad queue count");

  property p_take_valid;
    @(posedge clk) disable iff (rst) q_take |-> q_valid;
  endproperty
  a_take_valid: assert property (p_take_valid) else $error("take from empty");

endmodule

// ===== hdl/dfga_back.sv =====
//------------------------------------------------------------------------------
// dfga_back
// Sequenced arithmetic engine: works one pair through a chain of registered
// multiplies, then accumulates the six tensor sums and emits on the last pair.
//------------------------------------------------------------------------------
module dfga_back import dfga_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FRAC_BITS  = FracBitsDef,
  parameter int ACC_WIDTH  = AccWidthDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [CfgWidth-1:0]   coef_k,
  input  logic                         q_valid,
  output logic                         q_take,
  input  logic signed [DATA_WIDTH-1:0] rx, ry, rz, mx, my, mz,
  input  logic        [DATA_WIDTH-1:0] inv5, inv7,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ACC_WIDTH-1:0]  o_xx, o_yy, o_zz, o_xy, o_xz, o_yz,
  output logic                         o_sat
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = ACC_WIDTH;
  localparam int EW = DW + 1;

  // Sequencer steps.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1   = 4'd1;
  localparam logic [3:0] S_P2   = 4'd2;
  localparam logic [3:0] S_P3   = 4'd3;
  localparam logic [3:0] S_P4   = 4'd4;
  localparam logic [3:0] S_T    = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0] state;
  logic [2:0] lane;
  logic [3:0] cnt;
  logic       busy_last;
  logic       emit;

  logic signed [DW-1:0] kc;
  logic signed [DW-1:0] pp [6];
  logic signed [DW-1:0] qq [6];
  logic signed [DW-1:0] pval, cval, dval, kinv5, kp;
  logic signed [DW-1:0] dr [3];
  logic signed [AW-1:0] sum [6];
  logic                 sat_flag;

  // Multiplier operands chosen by step.
  logic signed [DW-1:0] ma0, mb0;
  logic signed [EW-1:0] ma1, mb1;
  logic signed [DW-1:0] my0, my1, my2;
  logic signed [AW-1:0] ya, yb;
  logic signed [DW-1:0] ra;
  logic signed [DW-1:0] inner, dri, rj;
  logic signed [DW-1:0] rsel [3];

  assign kc = DW'(coef_k);
  assign rsel[0] = rx;
  assign rsel[1] = ry;
  assign rsel[2] = rz;

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      sadd = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      sadd = s[DW-1:0];
    end
  endfunction

  function automatic logic signed [AW-1:0] aadd(input logic signed [AW-1:0] a,
                                                input logic signed [AW-1:0] b);
    logic signed [AW:0] s;
    s = {a[AW-1], a} + {b[AW-1], b};
    if (s[AW] != s[AW-1]) begin
      aadd = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      aadd = s[AW-1:0];
    end
  endfunction

  // Lane operand pairs: index 0..2 diagonal, 3..5 off-diagonal.
  always_comb begin
    unique case (lane)
      3'd0: begin inner = sadd(qq[0], pval); dri = dr[0]; rj = rx; end
      3'd1: begin inner = sadd(qq[1], pval); dri = dr[1]; rj = ry; end
      3'd2: begin inner = sadd(qq[2], pval); dri = dr[2]; rj = rz; end
      3'd3: begin inner = sadd(pp[3], qq[3]); dri = dr[0]; rj = ry; end
      3'd4: begin inner = sadd(pp[4], qq[4]); dri = dr[0]; rj = rz; end
      default: begin inner = sadd(pp[5], qq[5]); dri = dr[1]; rj = rz; end
    endcase
  end

  // Two multipliers with data-width results, shared by the steps.
  always_comb begin
    ma0 = mx; mb0 = rx;
    ma1 = EW'(mx); mb1 = EW'(rx);
    unique case (state)
      S_P1: begin ma0 = mx; mb0 = rx; ma1 = EW'(kc); mb1 = $signed({1'b0, inv5}); end
      S_P2: begin ma0 = my; mb0 = ry; ma1 = EW'(my); mb1 = EW'(rx); end
      S_P3: begin ma0 = mz; mb0 = rz; ma1 = EW'(mz); mb1 = EW'(rx); end
      S_P4: begin
        // First mx*ry and mz*ry, then mx*rz and my*rz.
        if (cnt < 4'd2) begin
          ma0 = mx; mb0 = ry; ma1 = EW'(mz); mb1 = EW'(ry);
        end else begin
          ma0 = mx; mb0 = rz; ma1 = EW'(my); mb1 = EW'(rz);
        end
      end
      default: begin ma0 = mx; mb0 = rz; ma1 = EW'(my); mb1 = EW'(rz); end
    endcase
  end

  logic en_m;
  assign en_m = 1'b1;

  dfga_mul #(.AW(DW), .BW(DW), .OW(DW), .FRAC_BITS(FRAC_BITS)) u_m0 (
    .clk(clk), .en(en_m), .a(ma0), .b(mb0), .y(my0));
  dfga_mul #(.AW(EW), .BW(EW), .OW(DW), .FRAC_BITS(FRAC_BITS)) u_m1 (
    .clk(clk), .en(en_m), .a(ma1), .b(mb1), .y(my1));

  // Scalar chain: k*P, kP*inv7, -15*that, 3*kinv5, D*r.
  logic signed [EW-1:0] sa, sb;
  logic [2:0] sstep;
  always_comb begin
    unique case (sstep)
      3'd0: begin sa = EW'(kc);   sb = EW'(pval); end
      3'd1: begin sa = EW'(kp);   sb = $signed({1'b0, inv7}); end
      3'd2: begin sa = EW'(DW'(3) <<< FRAC_BITS); sb = EW'(kinv5); end
      3'd3: begin sa = -(EW'(15) <<< FRAC_BITS);  sb = EW'(my2); end
      default: begin
        sa = EW'(dval);
        sb = EW'(rsel[lane[1:0] == 2'd3 ? 2'd0 : lane[1:0]]);
      end
    endcase
  end
  dfga_mul #(.AW(EW), .BW(EW), .OW(DW), .FRAC_BITS(FRAC_BITS)) u_m2 (
    .clk(clk), .en(en_m), .a(sa), .b(sb), .y(my2));

  dfga_mul #(.AW(DW), .BW(DW), .OW(AW), .FRAC_BITS(FRAC_BITS)) u_t1 (
    .clk(clk), .en(en_m), .a(ra), .b(inner), .y(ya));
  dfga_mul #(.AW(DW), .BW(DW), .OW(AW), .FRAC_BITS(FRAC_BITS)) u_t2 (
    .clk(clk), .en(en_m), .a(dri), .b(rj), .y(yb));
  assign ra = cval;

  logic                 clip;
  logic signed [AW-1:0] tsum, nsum;
  logic signed [AW:0]   wsum;

  always_comb begin
    tsum = aadd(ya, yb);
    wsum = {sum[lane][AW-1], sum[lane]} + {tsum[AW-1], tsum};
    clip = (wsum[AW] != wsum[AW-1]);
    nsum = aadd(sum[lane], tsum);
  end

  // The head item stays in the queue while it is worked and is released on
  // the cycle the engine finishes with it.
  assign emit   = (state == S_OUT) && (!out_valid || out_ready);
  assign q_take = q_valid && (((state == S_ACC) && (lane == 3'd5) && !busy_last) || emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lane <= 3'd0;
      cnt <= 4'd0;
      sstep <= 3'd0;
      out_valid <= 1'b0;
      sat_flag <= 1'b0;
      busy_last <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        sum[i] <= '0;
      end
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            busy_last <= last;
            state <= S_P1;
            cnt <= 4'd0;
          end
        end
        S_P1: begin
          // wait for the registered mult results
          if (cnt == 4'd1) begin
            pp[0] <= my0; kinv5 <= my1;
            state <= S_P2; cnt <= 4'd0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_P2: begin
          if (cnt == 4'd1) begin
            pp[1] <= my0; pp[3] <= my1;
            state <= S_P3; cnt <= 4'd0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_P3: begin
          if (cnt == 4'd1) begin
            pp[2] <= my0; pp[4] <= my1;
            pval <= sadd(sadd(pp[0], pp[1]), my0);
            state <= S_P4; cnt <= 4'd0;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_P4: begin
          // qq: mx*ry, mx*rz, then my*rz; pp5: mz*ry. Scalar chain runs here.
          cnt <= cnt + 4'd1;
          unique case (cnt)
            4'd1: begin qq[3] <= my0; pp[5] <= my1; end
            4'd3: begin qq[4] <= my0; qq[5] <= my1; end
            default: begin end
          endcase
          unique case (cnt)
            4'd0: sstep <= 3'd0;
            4'd2: begin kp <= my2; sstep <= 3'd1; end
            4'd4: begin sstep <= 3'd3; end
            4'd6: begin dval <= my2; sstep <= 3'd2; end
            4'd8: begin cval <= my2; sstep <= 3'd4; lane <= 3'd0; end
            4'd10: begin dr[0] <= my2; lane <= 3'd1; end
            4'd12: begin dr[1] <= my2; lane <= 3'd2; end
            4'd14: begin dr[2] <= my2; lane <= 3'd0; state <= S_T; cnt <= 4'd0; end
            default: begin end
          endcase
          // 2*m_i*r_i via doubling with saturation
          qq[0] <= sadd(pp[0], pp[0]);
          qq[1] <= sadd(pp[1], pp[1]);
          qq[2] <= sadd(pp[2], pp[2]);
        end
        S_T: begin
          if (cnt == 4'd1) begin
            state <= S_ACC;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_ACC: begin
          sum[lane] <= nsum;
          if (clip) begin
            sat_flag <= 1'b1;
          end
          cnt <= 4'd0;
          if (lane == 3'd5) begin
            lane <= 3'd0;
            state <= busy_last ? S_OUT : S_IDLE;
          end else begin
            lane <= lane + 3'd1;
            state <= S_T;
          end
        end
        S_OUT: begin
          if (emit) begin
            o_xx <= sum[0]; o_yy <= sum[1]; o_zz <= sum[2];
            o_xy <= sum[3]; o_xz <= sum[4]; o_yz <= sum[5];
            o_sat <= sat_flag;
            sat_flag <= 1'b0;
            for (int i = 0; i < 6; i++) begin
              sum[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_take_done;
    @(posedge clk) disable iff (rst) q_take |-> (state == S_ACC || state == S_OUT);
  endproperty
  a_take_done: assert property (p_take_done) else $error("take while busy");

  property p_out_clear;
    @(posedge clk) disable iff (rst)
      (state == S_OUT && (!out_valid || out_ready)) |=> sum[0] == '0 && !sat_flag;
  endproperty
  a_out_clear: assert property (p_out_clear) else $error("sums not cleared");

  property p_lane_range;
    @(posedge clk) disable iff (rst) state == S_ACC |-> lane <= 3'd5;
  endproperty
  a_lane_range: assert property (p_lane_range) else $error("lane out of range");

endmodule

// ===== hdl/dipole_field_gradient_accumulate.sv =====
//------------------------------------------------------------------------------
// dipole_field_gradient_accumulate
// Accumulates the point-dipole field-gradient tensor over neighbour pairs.
//------------------------------------------------------------------------------
// Each accepted item is one neighbour pair. A two-entry queue holds the item
// being worked by the arithmetic engine and takes one more item meanwhile, so
// the input side can run ahead by one item. The engine uses a small set of
// registered fixed-point multipliers in turn: it forms the moment products
// and P, then the scalars C and D, then the six tensor terms, adding them
// one at a time into the saturating 48-bit sums, in the order set by that
// sequence of dependent multiplies. An item marked last also moves the six
// sums and the saturation flag into a held output register, and it waits
// there while the previous result is still unaccepted. The sums clear when
// they are emitted. The field coefficient is written through the APB port
// at address 0.
module dipole_field_gradient_accumulate import dfga_pkg::*; #(
  parameter int DATA_WIDTH = DataWidthDef,
  parameter int FRAC_BITS  = FracBitsDef,
  parameter int ACC_WIDTH  = AccWidthDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] rel_x, rel_y, rel_z,
  input  logic signed [DATA_WIDTH-1:0] moment_x, moment_y, moment_z,
  input  logic        [DATA_WIDTH-1:0] inv_dist_pow5, inv_dist_pow7,
  input  logic                         last_pair,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ACC_WIDTH-1:0]  grad_xx, grad_yy, grad_zz,
  output logic signed [ACC_WIDTH-1:0]  grad_xy, grad_xz, grad_yz,
  output logic                         saturated
);

  localparam int IW = 8 * DATA_WIDTH + 1;

  logic [CfgWidth-1:0] coef_k;
  logic [IW-1:0]       in_data, q_data;
  logic                q_valid, q_take;

  // Only the single register at address 0 is decoded.
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == RegFieldCoef) ? coef_k : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_k <= FieldCoefReset;
    end else if (psel && penable && pwrite && paddr == RegFieldCoef) begin
      coef_k <= pwdata;
    end
  end

  assign in_data = {rel_x, rel_y, rel_z, moment_x, moment_y, moment_z,
                    inv_dist_pow5, inv_dist_pow7, last_pair};

  dfga_front #(.IW(IW)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data));

  dfga_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH))
  u_back (
    .clk(clk), .rst(rst), .coef_k(coef_k),
    .q_valid(q_valid), .q_take(q_take),
    .rx(q_data[8*DATA_WIDTH:7*DATA_WIDTH+1]),
    .ry(q_data[7*DATA_WIDTH:6*DATA_WIDTH+1]),
    .rz(q_data[6*DATA_WIDTH:5*DATA_WIDTH+1]),
    .mx(q_data[5*DATA_WIDTH:4*DATA_WIDTH+1]),
    .my(q_data[4*DATA_WIDTH:3*DATA_WIDTH+1]),
    .mz(q_data[3*DATA_WIDTH:2*DATA_WIDTH+1]),
    .inv5(q_data[2*DATA_WIDTH:DATA_WIDTH+1]),
    .inv7(q_data[DATA_WIDTH:1]),
    .last(q_data[0]),
    .out_valid(out_valid), .out_ready(out_ready),
    .o_xx(grad_xx), .o_yy(grad_yy), .o_zz(grad_zz),
    .o_xy(grad_xy), .o_xz(grad_xz), .o_yz(grad_yz), .o_sat(saturated));

  property p_out_hold;
    @(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

endmodule
